// File: sv/pgg_pkg.sv
// ----------------------------------------------------------------------------
// pgg_pkg: shared constants for the polyrhythm gate generator
// Field widths, register count and parameter defaults.
// ----------------------------------------------------------------------------
package pgg_pkg;

  // Parameter defaults
  localparam int CHANNELS_DEF = 8;
  localparam int CV_MAX_DEF   = 4095;

  // Channel bookkeeping (gate_bits is fixed at eight lanes)
  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;

  // Field widths
  localparam int ELAPSED_W = 16;
  localparam int LOOP_W    = 24;
  localparam int GATE_W    = 13;
  localparam int GATE_MAG_W = GATE_W - 1;
  localparam int DIV_W     = 8;
  localparam int CV_W      = 16;
  localparam int PROD_W    = LOOP_W + CV_W;

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int NUM_REGS    = 8;

  // Divider iteration counter
  localparam int CNT_W = $clog2(LOOP_W);

endpackage

// File: sv/polyrhythm_gate_generator.sv
// ----------------------------------------------------------------------------
// polyrhythm_gate_generator
// Per-channel gate generator over a shared loop position, using one
// bit-serial divider and one multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// tick      in         tick_valid / tick_ready    elapsed_ticks, loop_length,
//                                                 gate_length
// gate      out        gate_valid / gate_ready    gate_bits
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// For each tick the sequencer walks the channels in turn: each
// channel runs the restoring divider twice (step length, then position
// remainder), then passes two multiply states and one compare state.
// tick_ready is high only while the sequencer is idle; the result sits in
// an output register, so a new tick is taken while it waits for gate_ready.
// Reset (rst, synchronous) clears the position and sets all divisors to 1.
// cfg_ready is always high; writes at indexes past the last are dropped.
// ----------------------------------------------------------------------------
module polyrhythm_gate_generator #(
  parameter int CHANNELS = pgg_pkg::CHANNELS_DEF,
  parameter int CV_MAX   = pgg_pkg::CV_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             tick_valid,
  output logic                             tick_ready,
  input  logic [pgg_pkg::ELAPSED_W-1:0]    elapsed_ticks,
  input  logic [pgg_pkg::LOOP_W-1:0]       loop_length,
  input  logic signed [pgg_pkg::GATE_W-1:0] gate_length,
  output logic                             gate_valid,
  input  logic                             gate_ready,
  output logic [pgg_pkg::MAX_CHANNELS-1:0] gate_bits,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pgg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pgg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = pgg_pkg::LOOP_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIV_STEP = 8'b0000_0010,
    S_DIV_REM  = 8'b0000_0100,
    S_MUL_A    = 8'b0000_1000,
    S_MUL_B    = 8'b0001_0000,
    S_CMP      = 8'b0010_0000,
    S_OUT      = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_t;

  state_t state;

  // Control registers
  logic [pgg_pkg::DIV_W-1:0]        divisors [pgg_pkg::NUM_REGS];
  logic [LW-1:0]                    pos;
  logic [pgg_pkg::CH_W-1:0]         ch;
  logic [pgg_pkg::CNT_W-1:0]        cnt;

  // Datapath registers
  logic [pgg_pkg::ELAPSED_W-1:0]    elapsed_q;
  logic [LW-1:0]                    loop_q;
  logic [pgg_pkg::GATE_MAG_W-1:0]   gate_q;
  logic [LW-1:0]                    dvd;
  logic [LW-1:0]                    racc;
  logic [LW-1:0]                    dvs;
  logic [LW-1:0]                    step;
  logic [pgg_pkg::PROD_W-1:0]       prod_lhs;
  logic [pgg_pkg::PROD_W-1:0]       prod_rhs;
  logic [pgg_pkg::MAX_CHANNELS-1:0] bits;

  // Divider step
  logic [LW:0]   trial;
  logic [LW:0]   diff;
  logic          take;
  logic [LW-1:0] racc_next;
  logic [LW-1:0] dvd_next;
  logic [LW-1:0] step_next;
  logic          cnt_last;

  // Shared multiplier
  logic [LW-1:0]                 mul_x;
  logic [pgg_pkg::CV_W-1:0]      mul_y;
  logic [pgg_pkg::PROD_W-1:0]    product;

  // Misc
  logic                          ch_last;
  logic [pgg_pkg::CH_W-1:0]      ch_inc;
  logic [LW:0]                   pos_sum;
  logic [LW-1:0]                 pos_next;
  logic                          tick_xfer;
  logic                          out_load;

  function automatic logic [LW-1:0] div_sel(input logic [pgg_pkg::DIV_W-1:0] d);
    logic [LW-1:0] r;
    r = {{(LW - pgg_pkg::DIV_W){1'b0}}, d};
    if (d == '0) begin
      r = LW'(1);
    end
    return r;
  endfunction

  assign tick_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign tick_xfer  = tick_valid && tick_ready;
  assign out_load   = (state == S_OUT) && (!gate_valid || gate_ready);

  // One restoring divider iteration
  always_comb begin
    trial     = {racc, dvd[LW-1]};
    diff      = trial - {1'b0, dvs};
    take      = !diff[LW];
    racc_next = take ? diff[LW-1:0] : trial[LW-1:0];
    dvd_next  = {dvd[LW-2:0], take};
    step_next = (dvd_next == '0) ? LW'(1) : dvd_next;
    cnt_last  = (cnt == pgg_pkg::CNT_W'(LW - 1));
  end

  // Multiplier operand select
  always_comb begin
    if (state == S_MUL_A) begin
      mul_x = racc;
      mul_y = pgg_pkg::CV_W'(CV_MAX);
    end else begin
      mul_x = step;
      mul_y = {{(pgg_pkg::CV_W - pgg_pkg::GATE_MAG_W){1'b0}}, gate_q};
    end
    product = {{pgg_pkg::CV_W{1'b0}}, mul_x} * {{LW{1'b0}}, mul_y};
  end

  // Channel walk and position advance
  always_comb begin
    ch_last  = (ch == pgg_pkg::CH_W'(CHANNELS - 1));
    ch_inc   = ch + pgg_pkg::CH_W'(1);
    pos_sum  = {1'b0, pos} + {{(LW + 1 - pgg_pkg::ELAPSED_W){1'b0}}, elapsed_q};
    pos_next = (pos_sum >= {1'b0, loop_q}) ? '0 : pos_sum[LW-1:0];
  end

  // Sequencer, position, output register and divisor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      ch         <= '0;
      cnt        <= '0;
      gate_valid <= 1'b0;
      for (int i = 0; i < pgg_pkg::NUM_REGS; i++) begin
        divisors[i] <= pgg_pkg::DIV_W'(1);
      end
    end else begin
      if (cfg_valid && cfg_ready && (cfg_index < pgg_pkg::CFG_INDEX_W'(pgg_pkg::NUM_REGS))) begin
        divisors[cfg_index[pgg_pkg::CH_W-1:0]] <= cfg_data;
      end
      // Raise the result on load, drop it after its transfer
      if (out_load) begin
        gate_valid <= 1'b1;
      end else if (gate_valid && gate_ready) begin
        gate_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick_xfer) begin
            ch    <= '0;
            cnt   <= '0;
            state <= S_DIV_STEP;
          end
        end
        S_DIV_STEP: begin
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_DIV_REM;
          end else begin
            cnt <= cnt + pgg_pkg::CNT_W'(1);
          end
        end
        S_DIV_REM: begin
          if (cnt_last) begin
            cnt   <= '0;
            state <= S_MUL_A;
          end else begin
            cnt <= cnt + pgg_pkg::CNT_W'(1);
          end
        end
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_CMP;
        S_CMP: begin
          if (ch_last) begin
            state <= S_OUT;
          end else begin
            ch    <= ch_inc;
            state <= S_DIV_STEP;
          end
        end
        S_OUT: begin
          if (out_load) begin
            pos   <= pos_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: operand capture, divider, products, gate bits
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (tick_xfer) begin
          elapsed_q <= elapsed_ticks;
          loop_q    <= loop_length;
          gate_q    <= gate_length[pgg_pkg::GATE_W-1] ? '0
                                                      : gate_length[pgg_pkg::GATE_MAG_W-1:0];
          bits      <= '0;
          dvd       <= loop_length;
          racc      <= '0;
          dvs       <= div_sel(divisors[0]);
        end
      end
      S_DIV_STEP: begin
        if (cnt_last) begin
          // load the remainder pass: position over step length
          step <= step_next;
          dvs  <= step_next;
          dvd  <= pos;
          racc <= '0;
        end else begin
          racc <= racc_next;
          dvd  <= dvd_next;
        end
      end
      S_DIV_REM: begin
        racc <= racc_next;
        dvd  <= dvd_next;
      end
      S_MUL_A: prod_lhs <= product;
      S_MUL_B: prod_rhs <= product;
      S_CMP: begin
        bits[ch] <= (prod_lhs < prod_rhs);
        if (!ch_last) begin
          dvd  <= loop_q;
          racc <= '0;
          dvs  <= div_sel(divisors[ch_inc]);
        end
      end
      S_OUT: begin
        if (out_load) begin
          gate_bits <= bits;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/pgg_checker.sv
// ----------------------------------------------------------------------------
// pgg_checker: port-level checks for the polyrhythm gate generator
// Watches the handshake ports and the result over time.
// ----------------------------------------------------------------------------
module pgg_checker #(
  parameter int CHANNELS = pgg_pkg::CHANNELS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             tick_valid,
  input logic                             tick_ready,
  input logic                             gate_valid,
  input logic                             gate_ready,
  input logic [pgg_pkg::MAX_CHANNELS-1:0] gate_bits,
  input logic                             cfg_ready
);

  // Hold a stalled result
  a_gate_hold: assert property (@(posedge clk) disable iff (rst)
    gate_valid && !gate_ready |=> gate_valid && $stable(gate_bits))
    else $error("gate result changed or dropped while stalled");

  // Drop tick_ready after a transfer while the item is worked on
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick_ready stayed high after a tick transfer");

  // A result never appears the cycle right after a tick transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !$rose(gate_valid))
    else $error("gate result appeared one cycle after a tick");

  // Keep unused channel bits low
  a_unused_low: assert property (@(posedge clk) disable iff (rst)
    gate_valid |-> ((gate_bits >> CHANNELS) == '0))
    else $error("gate bit set above the channel count");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg_ready low");

endmodule

bind polyrhythm_gate_generator pgg_checker #(.CHANNELS(CHANNELS)) u_pgg_checker (
  .clk        (clk),
  .rst        (rst),
  .tick_valid (tick_valid),
  .tick_ready (tick_ready),
  .gate_valid (gate_valid),
  .gate_ready (gate_ready),
  .gate_bits  (gate_bits),
  .cfg_ready  (cfg_ready)
);
